// ===== rtl/lrupr_pkg.sv =====
// Shared constants, types and control structs for the LRU page replacement core.
`default_nettype none

package lrupr_pkg;

  localparam int MAX_FRAMES         = 16;
  localparam int INITIAL_AGE_MARGIN = 256;

  localparam int PAGE_W  = 16;
  localparam int AGE_W   = 16;
  localparam int CFG_W   = 5;
  localparam int FRAME_W = 4;

  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_RAW = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W   = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;

  localparam int OUT_DATA_W = ((PAGE_W + FRAME_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam age_t AGE_MAX  = {AGE_W{1'b1}};
  localparam age_t AGE_INIT = AGE_MAX - AGE_W'(INITIAL_AGE_MARGIN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture page, restart scan
    logic scan;    // examine one frame
    logic commit;  // update frames, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // current frame is the last in use
    logic out_free;   // result register can take a new item
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/lru_page_replacement_core.sv =====
// Top level of the LRU page replacement core: stream ports, controller and datapath.
//
// Usage:
//  - Input stream (s_axis_*): one item is one page reference; tdata[15:0] holds
//    page_number. An item is taken when tvalid and tready are both high.
//  - Output stream (m_axis_*): exactly one item per reference. tuser[0] is the
//    fault flag (1 = page fault); tdata[15:0] is the evicted page (0 on a hit),
//    tdata[19:16] the frame that was hit or refilled; tdata[23:20] are zero.
//  - Config: cfg_we_i writes cfg_wdata_i into active_frames (0 acts as 1, above
//    16 acts as 16). Write only while the core is idle.
//  - Timing: the frame table is searched one frame per cycle over the N frames
//    in use; after the scan a commit step loads the result into the output register.
//    One item is in work at a time; the next one is taken as soon as the
//    previous result sits in the output register.
//  - Reset: all pages 0 (page 0 hits at first), all ages 65535 - 256,
//    active_frames 16, output stream empty.
//  - Stall: if m_axis_tready is low, the result is held in the output
//    register; a following item is searched but waits before commit until
//    the held result is taken.
`default_nettype none

module lru_page_replacement_core (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration: active_frames
  input  wire                                   cfg_we_i,
  input  wire  [lrupr_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input stream
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [lrupr_pkg::PAGE_W-1:0]          s_axis_tdata,   // [15:0] page_number
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [lrupr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [15:0] victim_page,
                                                                // [19:16] frame_used, pad
  output logic                                  m_axis_tuser    // [0] fault
);

  lrupr_pkg::cmd_t cmd;
  lrupr_pkg::sts_t sts;

  logic                          out_fault;
  logic [lrupr_pkg::PAGE_W-1:0]  out_victim;
  logic [lrupr_pkg::FRAME_W-1:0] out_frame;

  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrupr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .page_i       (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_fault_o  (out_fault),
    .out_victim_o (out_victim),
    .out_frame_o  (out_frame)
  );

  // pack result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = lrupr_pkg::OUT_DATA_W'({out_frame, out_victim});
  assign m_axis_tuser = out_fault;

endmodule

`default_nettype wire

// ===== rtl/lrupr_ctrl.sv =====
// Sequencing state machine: accept, scan frames, commit result.
`default_nettype none

module lrupr_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lrupr_pkg::sts_t  sts_i,
  output lrupr_pkg::cmd_t  cmd_o
);

  lrupr_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lrupr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lrupr_pkg::ST_SCAN;
        end
      end
      lrupr_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = lrupr_pkg::ST_UPD;
        end
      end
      lrupr_pkg::ST_UPD: begin
        // wait here while the previous result is still held downstream
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrupr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrupr_dp.sv =====
// Frame tables, sequential hit / oldest-frame search, aging and result register.
`default_nettype none

module lrupr_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [lrupr_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire  [lrupr_pkg::PAGE_W-1:0]          page_i,
  input  lrupr_pkg::cmd_t                       cmd_i,
  output lrupr_pkg::sts_t                       sts_o,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic                                  out_fault_o,
  output logic [lrupr_pkg::PAGE_W-1:0]          out_victim_o,
  output logic [lrupr_pkg::FRAME_W-1:0]         out_frame_o
);

  logic [lrupr_pkg::CFG_W-1:0] cfg_q;

  lrupr_pkg::page_t pages_q [lrupr_pkg::MAX_FRAMES];
  lrupr_pkg::age_t  ages_q  [lrupr_pkg::MAX_FRAMES];

  lrupr_pkg::page_t page_q;
  lrupr_pkg::idx_t  idx_q;
  logic             hit_q;
  lrupr_pkg::idx_t  hit_slot_q;
  lrupr_pkg::age_t  max_age_q;
  lrupr_pkg::idx_t  max_slot_q;
  lrupr_pkg::page_t max_page_q;

  logic             out_valid_q;
  logic             out_fault_q;
  lrupr_pkg::page_t out_victim_q;
  logic [lrupr_pkg::FRAME_W-1:0] out_frame_q;

  logic [lrupr_pkg::CNT_W-1:0] cfg_ext;
  logic [lrupr_pkg::CNT_W-1:0] eff_cnt;
  lrupr_pkg::idx_t             last_idx;
  lrupr_pkg::page_t            rd_page;
  lrupr_pkg::age_t             rd_age;
  lrupr_pkg::idx_t             slot;

  // effective frame count: 0 acts as 1, above the table size clamps
  always_comb begin
    cfg_ext = lrupr_pkg::CNT_W'(cfg_q);
    if (cfg_q == '0) begin
      eff_cnt = lrupr_pkg::CNT_W'(1);
    end else if (cfg_ext > lrupr_pkg::CNT_W'(lrupr_pkg::MAX_FRAMES)) begin
      eff_cnt = lrupr_pkg::CNT_W'(lrupr_pkg::MAX_FRAMES);
    end else begin
      eff_cnt = cfg_ext;
    end
  end

  assign last_idx = lrupr_pkg::IDX_W'(eff_cnt - lrupr_pkg::CNT_W'(1));
  assign rd_page  = pages_q[idx_q];
  assign rd_age   = ages_q[idx_q];
  assign slot     = hit_q ? hit_slot_q : max_slot_q;

  assign sts_o.scan_done = (idx_q == last_idx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_fault_o  = out_fault_q;
  assign out_victim_o = out_victim_q;
  assign out_frame_o  = out_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lrupr_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + lrupr_pkg::IDX_W'(1);
      if (!hit_q && (rd_page == page_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_i;
    end
    if (cmd_i.scan) begin
      if (!hit_q && (rd_page == page_q)) begin
        hit_slot_q <= idx_q;
      end
      // strict compare keeps the lowest index on ties
      if ((idx_q == '0) || (rd_age > max_age_q)) begin
        max_age_q  <= rd_age;
        max_slot_q <= idx_q;
        max_page_q <= rd_page;
      end
    end
  end

  // frame tables: refill on miss, set the used frame's age to 1, age frames in use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
        pages_q[i] <= '0;
        ages_q[i]  <= lrupr_pkg::AGE_INIT;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
        if (lrupr_pkg::IDX_W'(i) <= last_idx) begin
          if (lrupr_pkg::IDX_W'(i) == slot) begin
            ages_q[i] <= lrupr_pkg::AGE_W'(1);
            if (!hit_q) begin
              pages_q[i] <= page_q;
            end
          end else if (ages_q[i] != lrupr_pkg::AGE_MAX) begin
            ages_q[i] <= ages_q[i] + lrupr_pkg::AGE_W'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_fault_q  <= !hit_q;
      out_victim_q <= hit_q ? '0 : max_page_q;
      out_frame_q  <= lrupr_pkg::FRAME_W'(slot);
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LRU page replacement core.
`timescale 1ns / 1ps

module tb_top;
  import lrupr_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int MAX_ERR_PRINTS  = 40;

  typedef struct packed {
    logic             fault;
    page_t            victim;
    logic [FRAME_W-1:0] frame;
  } lru_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PAGE_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  lru_page_replacement_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // page references still to be sent, results still to arrive
  page_t       page_feed_q[$];
  lru_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic in_done = 1'b0;   // input item taken at the last rising edge

  // shadow of the frame table
  logic [CFG_W-1:0] active_frames_reg;
  page_t            resident_page[MAX_FRAMES];
  age_t             frame_age[MAX_FRAMES];

  int err_cnt   = 0;
  int hit_cnt   = 0;
  int fault_cnt = 0;
  int sat_seen  = 0;   // frame ages seen pinned at the top, one count per reference and frame

  // Look up one page, replace on a miss, then age the frames in use.
  function automatic lru_result_t lookup_and_replace(input page_t pg);
    lru_result_t r;
    int          n;
    int          slot;
    logic        hit;
    n    = (active_frames_reg == 0) ? 1 :
           (active_frames_reg > MAX_FRAMES) ? MAX_FRAMES : int'(active_frames_reg);
    slot = 0;
    hit  = 1'b0;
    r    = '0;
    for (int i = 0; i < n; i++) begin
      if (!hit && resident_page[i] == pg) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      // oldest frame wins, lowest index on a tie
      for (int i = 1; i < n; i++) begin
        if (frame_age[i] > frame_age[slot]) slot = i;
      end
      r.victim            = resident_page[slot];
      resident_page[slot] = pg;
    end
    frame_age[slot] = '0;
    for (int i = 0; i < n; i++) begin
      if (frame_age[i] == AGE_MAX) sat_seen++;
      else frame_age[i] = frame_age[i] + 1'b1;
    end
    r.fault = !hit;
    r.frame = FRAME_W'(slot);
    return r;
  endfunction

  // Driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_done) begin
        if (page_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= page_feed_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: config shadow, prediction on accepted references, result check.
  always @(posedge clk_i) begin
    lru_result_t want;
    if (!rst_ni) begin
      active_frames_reg <= CFG_RESET;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        resident_page[i] = '0;
        frame_age[i]     = AGE_INIT;
      end
      in_done <= 1'b0;
    end else begin
      if (cfg_we_i) active_frames_reg <= cfg_wdata_i;
      in_done <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(lookup_and_replace(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_ERR_PRINTS)
            $display("%0t: unexpected result tuser=%0b tdata=%h", $time,
                     m_axis_tuser, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (want.fault) fault_cnt++;
          else hit_cnt++;
          if (m_axis_tuser !== want.fault || m_axis_tdata[15:0] !== want.victim ||
              m_axis_tdata[19:16] !== want.frame || m_axis_tdata[23:20] !== 4'h0) begin
            err_cnt++;
            if (err_cnt <= MAX_ERR_PRINTS)
              $display("%0t: exp fault=%0b victim=%h frame=%0d, got %0b %h %0d pad=%h",
                       $time, want.fault, want.victim, want.frame, m_axis_tuser,
                       m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tdata[23:20]);
          end
        end
      end
    end
  end

  // block until every reference has gone in and every result has come out
  task automatic wait_drained();
    while (page_feed_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] frame_setting[PHASES];
    page_t            work_set[$];
    int               n_eff;
    int               ws_size;
    frame_setting = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd17, 5'd2, 5'd8, 5'd0};
    frame_setting[PHASES-1] = CFG_W'($urandom_range(3, 15));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: page 0 hits right after reset, field extremes, bit patterns,
    // a re-hit, then enough fresh pages to evict through all 16 frames.
    page_feed_q = '{16'h0000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF,
                    16'h0001, 16'h8000, 16'h7FFF, 16'h0000};
    for (int i = 0; i < 12; i++) page_feed_q.push_back(page_t'(16'h0100 + i));
    page_feed_q.push_back(16'h5555);
    page_feed_q.push_back(16'h0000);

    // Random phases: each picks a frame count and an idle pattern; most
    // references come from a working set so hits, LRU order and age
    // saturation are all exercised, the rest are arbitrary pages.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_frame_count(frame_setting[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      n_eff = (frame_setting[ph] == 0) ? 1 :
              (frame_setting[ph] > MAX_FRAMES) ? MAX_FRAMES : int'(frame_setting[ph]);
      ws_size = $urandom_range(1, n_eff + 3);
      work_set.delete();
      for (int i = 0; i < ws_size; i++) begin
        if ($urandom_range(1)) work_set.push_back(page_t'($urandom_range(0, 31)));
        else work_set.push_back(page_t'($urandom_range(0, 65535)));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 85)
          page_feed_q.push_back(work_set[$urandom_range(0, ws_size - 1)]);
        else
          page_feed_q.push_back(page_t'($urandom_range(0, 65535)));
      end
    end

    wait_drained();
    repeat (4 * (MAX_FRAMES + 2)) @(posedge clk_i);

    $display("Covered %0d hits and %0d page faults over %0d frame-count settings,",
             hit_cnt, fault_cnt, PHASES + 1);
    $display("with sender/receiver idling phases; %0d aged frames were saturated.",
             sat_seen);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
